// ===== design/agn_pkg.sv =====
// ----------------------------------------------------------------------------
// agn_pkg
// Shared constants, state types and arithmetic limits of the block gain
// normalizer.
// ----------------------------------------------------------------------------
package agn_pkg;

    localparam int AGN_MAX_BLOCK = 1024;   // default sample capacity of one bank
    localparam int CFG_W         = 11;     // block_length register width
    localparam int SAMPLE_W      = 16;
    localparam int GAIN_W        = 16;     // unsigned Q4.12
    localparam int GAIN_FRAC     = 12;
    localparam int RESET_LEN     = 960;
    localparam int GAIN_UNITY    = 4096;
    localparam int GAIN_MIN      = 410;
    localparam int GAIN_MAX      = 40960;
    localparam int LEVEL_NUM     = 15625;  // sum * 15625 <= N * 512 means level <= 1e-6
    localparam int LEVEL_SHIFT   = 9;
    localparam int DIV_SHIFT     = 27;     // N * 2^27 / (10 * sum)
    localparam int DIV_SCALE     = 10;
    localparam int Q_DEPTH       = 4;      // front-to-back queue entries

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_OUT,
        BK_GAIN
    } t_back_state;

    typedef enum logic [2:0] {
        GN_IDLE,
        GN_MUL,
        GN_CMP,
        GN_DIV,
        GN_DONE
    } t_gain_state;

endpackage

// ===== design/agn_queue.sv =====
// ----------------------------------------------------------------------------
// agn_queue
// Short first-word-fall-through queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module agn_queue
    import agn_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_in_ready,
    input  logic             i_pop,
    output logic             o_out_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_in_ready  = (r_count != CNT_W'(DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];
    assign w_push      = i_push && o_in_ready;
    assign w_pop       = i_pop && o_out_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// ===== design/agn_front.sv =====
// ----------------------------------------------------------------------------
// agn_front
// Accepts samples, holds block_length, tracks the position in the block and
// tags each word with its position, the block length and an end-of-block flag.
// ----------------------------------------------------------------------------
module agn_front
    import agn_pkg::*;
#(
    parameter int MAX_BLOCK = AGN_MAX_BLOCK,
    parameter int POS_W     = $clog2(MAX_BLOCK),
    parameter int LEN_W     = $clog2(MAX_BLOCK + 1),
    parameter int ENTRY_W   = 1 + LEN_W + POS_W + SAMPLE_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_block_length,
    input  logic                i_q_ready,
    output logic                o_q_push,
    output logic [ENTRY_W-1:0]  o_q_data
);

    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    logic [CFG_W-1:0] r_block_length;
    logic [POS_W-1:0] r_count, n_count;
    logic [CMP_W-1:0] w_len_ext;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_count_inc;
    logic             w_last;
    logic             w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_q_ready;
    assign w_accept    = i_valid && i_q_ready;

    // effective length: zero counts as one, clamp to bank capacity
    always_comb begin
        w_len_ext = CMP_W'(r_block_length);
        if (r_block_length == '0) begin
            w_len_ext = CMP_W'(1);
        end else if (CMP_W'(r_block_length) > CMP_W'(MAX_BLOCK)) begin
            w_len_ext = CMP_W'(MAX_BLOCK);
        end
        w_len = w_len_ext[LEN_W-1:0];
    end

    assign w_count_inc = LEN_W'(r_count) + 1'b1;
    assign w_last      = (w_count_inc >= w_len);
    assign n_count     = w_last ? '0 : w_count_inc[POS_W-1:0];

    assign o_q_push = w_accept;
    assign o_q_data = {w_last, w_len, r_count, i_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= CFG_W'(RESET_LEN);
            r_count        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_block_length <= i_cfg_block_length;
            end
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

endmodule

// ===== design/agn_gain.sv =====
// ----------------------------------------------------------------------------
// agn_gain
// Block gain unit: silence check by one multiply, then a restoring divider
// forming floor(N * 2^27 / (10 * sum)) one quotient bit per cycle, clamped.
// ----------------------------------------------------------------------------
module agn_gain
    import agn_pkg::*;
#(
    parameter int LEN_W = 11,
    parameter int SUM_W = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_done,
    output logic [GAIN_W-1:0] o_gain
);

    localparam int DIV_W  = SUM_W + 4;
    localparam int DVD_W  = LEN_W + DIV_SHIFT;
    localparam int PROD_W = SUM_W + 14;
    localparam int CNT_W  = $clog2(DVD_W);

    t_gain_state r_state, n_state;

    logic [LEN_W-1:0]  r_len;
    logic [SUM_W-1:0]  r_sum;
    logic [DIV_W-1:0]  r_div;
    logic [PROD_W-1:0] r_prod;
    logic [DIV_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_bit;
    logic              r_unity;
    logic              w_silent;
    logic [DIV_W:0]    w_rem_sh;
    logic              w_ge;
    logic [DIV_W:0]    w_rem_sub;

    assign w_silent  = (r_prod <= (PROD_W'(r_len) << LEVEL_SHIFT));
    assign w_rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            GN_IDLE: if (i_start) n_state = GN_MUL;
            GN_MUL:  n_state = GN_CMP;
            GN_CMP:  n_state = w_silent ? GN_DONE : GN_DIV;
            GN_DIV:  if (r_bit == '0) n_state = GN_DONE;
            GN_DONE: n_state = GN_IDLE;
            default: n_state = GN_IDLE;
        endcase
    end

    // clamp the quotient, or hand back unity for a silent block
    always_comb begin
        o_done = (r_state == GN_DONE);
        if (r_unity) begin
            o_gain = GAIN_W'(GAIN_UNITY);
        end else if (r_dvd < DVD_W'(GAIN_MIN)) begin
            o_gain = GAIN_W'(GAIN_MIN);
        end else if (r_dvd > DVD_W'(GAIN_MAX)) begin
            o_gain = GAIN_W'(GAIN_MAX);
        end else begin
            o_gain = r_dvd[GAIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            GN_IDLE: begin
                if (i_start) begin
                    r_len <= i_len;
                    r_sum <= i_sum;
                    r_div <= DIV_W'(i_sum) * DIV_W'(DIV_SCALE);
                end
            end
            GN_MUL: begin
                r_prod <= PROD_W'(r_sum) * PROD_W'(LEVEL_NUM);
            end
            GN_CMP: begin
                r_unity <= w_silent;
                r_rem   <= '0;
                r_dvd   <= DVD_W'(r_len) << DIV_SHIFT;
                r_bit   <= CNT_W'(DVD_W - 1);
            end
            GN_DIV: begin
                // shift the dividend out at the top, quotient bits in at the bottom
                r_rem <= w_ge ? w_rem_sub[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
                r_bit <= r_bit - 1'b1;
            end
            GN_DONE: begin
            end
            default: begin
            end
        endcase
    end

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_gain >= GAIN_W'(GAIN_MIN)) && (o_gain <= GAIN_W'(GAIN_MAX)))
        else $error("block gain outside clamp range");

endmodule

// ===== design/agn_back.sv =====
// ----------------------------------------------------------------------------
// agn_back
// Back end: banked sample store, running magnitude sum, scaling multiply,
// output register and block-end gain update.
// ----------------------------------------------------------------------------
module agn_back
    import agn_pkg::*;
#(
    parameter int MAX_BLOCK = AGN_MAX_BLOCK,
    parameter int POS_W     = $clog2(MAX_BLOCK),
    parameter int LEN_W     = $clog2(MAX_BLOCK + 1),
    parameter int SUM_W     = $clog2(MAX_BLOCK * 32768 + 1),
    parameter int ENTRY_W   = 1 + LEN_W + POS_W + SAMPLE_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  logic [ENTRY_W-1:0]  i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_scaled_sample,
    output logic                o_scaled_valid,
    output logic                o_block_last
);

    localparam int ADDR_W = POS_W + 1;
    localparam int MEM_DEPTH = 2 << POS_W;
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int SHR_W  = PROD_W - GAIN_FRAC;

    t_back_state r_state, n_state;

    logic [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic                r_bank;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    r_blk_sum;
    logic [LEN_W-1:0]    r_len;
    logic                r_last;
    logic [GAIN_W-1:0]   r_gain;
    logic                r_prev_ready;
    logic signed [PROD_W-1:0] r_prod;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_scaled;
    logic                r_out_last;

    logic [SAMPLE_W-1:0] w_sample;
    logic [POS_W-1:0]    w_pos;
    logic [LEN_W-1:0]    w_len;
    logic                w_last;
    logic [SAMPLE_W-1:0] w_mag;
    logic [SUM_W-1:0]    w_sum_total;
    logic                w_pop;
    logic                w_out_load;
    logic                w_gain_start;
    logic                w_gain_done;
    logic [GAIN_W-1:0]   w_gain;
    logic signed [SHR_W-1:0]    w_shr;
    logic signed [SAMPLE_W-1:0] w_sat;

    assign w_sample = i_q_data[SAMPLE_W-1:0];
    assign w_pos    = i_q_data[SAMPLE_W+POS_W-1:SAMPLE_W];
    assign w_len    = i_q_data[SAMPLE_W+POS_W+LEN_W-1:SAMPLE_W+POS_W];
    assign w_last   = i_q_data[ENTRY_W-1];

    assign w_mag       = w_sample[SAMPLE_W-1] ? (~w_sample + 1'b1) : w_sample;
    assign w_sum_total = r_sum + SUM_W'(w_mag);

    // floor shift by the gain fraction, then saturate
    assign w_shr = SHR_W'(r_prod >>> GAIN_FRAC);
    always_comb begin
        if (w_shr > SHR_W'(signed'(32'sd32767))) begin
            w_sat = 16'sh7FFF;
        end else if (w_shr < SHR_W'(-32'sd32768)) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_shr[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_q_valid) n_state = BK_READ;
            BK_READ: n_state = BK_OUT;
            BK_OUT:  if (!r_out_valid || i_ready) n_state = r_last ? BK_GAIN : BK_IDLE;
            BK_GAIN: if (w_gain_done) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_pop        = (r_state == BK_IDLE) && i_q_valid;
        w_out_load   = (r_state == BK_OUT) && (!r_out_valid || i_ready);
        w_gain_start = w_out_load && r_last;
    end

    assign o_q_pop         = w_pop;
    assign o_valid         = r_out_valid;
    assign o_scaled_sample = r_out_sample;
    assign o_scaled_valid  = r_out_scaled;
    assign o_block_last    = r_out_last;

    agn_gain #(
        .LEN_W (LEN_W),
        .SUM_W (SUM_W)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gain_start),
        .i_len   (r_len),
        .i_sum   (r_blk_sum),
        .o_done  (w_gain_done),
        .o_gain  (w_gain)
    );

    // write the current bank, read the same position of the other bank
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_mem[ADDR_W'({r_bank, w_pos})] <= w_sample;
            r_rd_data <= r_mem[ADDR_W'({~r_bank, w_pos})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_len     <= w_len;
            r_last    <= w_last;
            r_blk_sum <= w_sum_total;
        end
        if (r_state == BK_READ) begin
            r_prod <= $signed(r_rd_data) * $signed({1'b0, r_gain});
        end
        if (w_out_load) begin
            r_out_sample <= r_prev_ready ? w_sat : '0;
            r_out_scaled <= r_prev_ready;
            r_out_last   <= r_prev_ready && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_bank       <= 1'b0;
            r_sum        <= '0;
            r_gain       <= GAIN_W'(GAIN_UNITY);
            r_prev_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                r_sum <= w_last ? '0 : w_sum_total;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == BK_GAIN) && w_gain_done) begin
                r_gain       <= w_gain;
                r_prev_ready <= 1'b1;
                r_bank       <= ~r_bank;
            end
        end
    end

    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_prev_ready))
        else $error("previous-block flag dropped outside reset");

    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_bank)) |-> $past(w_gain_done))
        else $error("bank swapped without a finished gain");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == BK_READ))
        else $error("popped word did not enter the read stage");

endmodule

// ===== design/block_audio_gain_normalizer.sv =====
// ----------------------------------------------------------------------------
// block_audio_gain_normalizer
// Block automatic gain control: one scaled sample of the previous block out
// for each sample in, with the gain set from the previous block's mean level.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid/o_ready, i_sample) takes signed Q1.15 samples.
//   Output channel (o_valid/i_ready) returns one word per input word:
//   o_scaled_sample, o_scaled_valid (low during the first block, sample 0)
//   and o_block_last on the final sample of each block after the first.
//   Config channel (i_cfg_valid/o_cfg_ready) writes block_length; write it
//   only while no words are in flight.
//   An accepted word passes the queue, then the back end's read, multiply
//   and output-register steps. The back end takes one word at a time; the
//   last word of a block also runs the gain divider, one quotient bit per
//   cycle (a silent block skips the divider), before the next word
//   is processed.
//   A 4-entry queue keeps taking input while the back end works or the
//   receiver stalls; o_ready drops only when it is full. A stalled output
//   word holds in the output register.
//   Reset sets block_length to 960, gain to unity and clears all control
//   state; the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
module block_audio_gain_normalizer
    import agn_pkg::*;
#(
    parameter int MAX_BLOCK = AGN_MAX_BLOCK
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_scaled_sample,
    output logic                o_scaled_valid,
    output logic                o_block_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_block_length
);

    localparam int POS_W   = $clog2(MAX_BLOCK);
    localparam int LEN_W   = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = $clog2(MAX_BLOCK * 32768 + 1);
    localparam int ENTRY_W = 1 + LEN_W + POS_W + SAMPLE_W;

    logic               w_q_ready;
    logic               w_q_push;
    logic [ENTRY_W-1:0] w_q_wdata;
    logic               w_q_valid;
    logic               w_q_pop;
    logic [ENTRY_W-1:0] w_q_rdata;

    agn_front #(
        .MAX_BLOCK (MAX_BLOCK),
        .POS_W     (POS_W),
        .LEN_W     (LEN_W),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample           (i_sample),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_block_length (i_cfg_block_length),
        .i_q_ready          (w_q_ready),
        .o_q_push           (w_q_push),
        .o_q_data           (w_q_wdata)
    );

    agn_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_data      (w_q_wdata),
        .o_in_ready  (w_q_ready),
        .i_pop       (w_q_pop),
        .o_out_valid (w_q_valid),
        .o_data      (w_q_rdata)
    );

    agn_back #(
        .MAX_BLOCK (MAX_BLOCK),
        .POS_W     (POS_W),
        .LEN_W     (LEN_W),
        .SUM_W     (SUM_W),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_data        (w_q_rdata),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_scaled_sample (o_scaled_sample),
        .o_scaled_valid  (o_scaled_valid),
        .o_block_last    (o_block_last)
    );

endmodule

// ===== tb/block_audio_gain_normalizer_tb.sv =====
// ----------------------------------------------------------------------------
// block_audio_gain_normalizer_tb
// Self-checking bench for the block gain normalizer. A predictor tracks both
// sample banks, the running level sum and the per-block gain, and queues one
// expected scaled word for every accepted input word. Directed tests cover
// the reset length, an out-of-range length, length shrink, one-sample blocks,
// the silence threshold and output saturation. Random phases then follow with
// mixed block lengths and signal levels. Sender bursts and receiver stalls
// are randomized throughout.
// ----------------------------------------------------------------------------
module block_audio_gain_normalizer_tb
    import agn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 80;
    localparam int RANDOM_WORDS = 550;
    localparam int REPORT_MAX   = 10;
    localparam int LEN_ALL_ONES = (1 << CFG_W) - 1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] scaled;
        logic                valid;
        logic                last;
    } t_scaled_word;

    typedef enum int {
        LVL_FULL,
        LVL_QUIET,
        LVL_SILENT,
        LVL_THRESHOLD,
        LVL_SPIKE,
        LVL_RAILS
    } t_level_style;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE,
        RX_CADENCE
    } t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [SAMPLE_W-1:0] i_sample;
    logic                o_valid;
    logic                i_ready;
    logic [SAMPLE_W-1:0] o_scaled_sample;
    logic                o_scaled_valid;
    logic                o_block_last;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_block_length;

    // predictor state
    logic [SAMPLE_W-1:0] bank_mem [0:2*AGN_MAX_BLOCK-1];
    int unsigned         written_top [0:1] = '{0, 0};
    int unsigned         bank_sel          = 0;
    int unsigned         blk_count         = 0;
    longint unsigned     level_sum         = 0;
    int unsigned         held_gain         = GAIN_UNITY;
    bit                  held_ready        = 1'b0;
    int unsigned         cfg_len           = RESET_LEN;

    t_scaled_word        scaled_due [$];
    int                  fail_count  = 0;
    int                  cycle_count = 0;
    int                  burst_left  = 0;

    block_audio_gain_normalizer u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample           (i_sample),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_scaled_sample    (o_scaled_sample),
        .o_scaled_valid     (o_scaled_valid),
        .o_block_last       (o_block_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_block_length (i_cfg_block_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned eff_len(input int unsigned len);
        if (len < 1) return 1;
        if (len > AGN_MAX_BLOCK) return AGN_MAX_BLOCK;
        return len;
    endfunction

    function automatic int unsigned block_gain_q412(input longint unsigned n,
                                                    input longint unsigned sum);
        longint unsigned g;
        if (sum * LEVEL_NUM <= (n << LEVEL_SHIFT)) return GAIN_UNITY;
        g = (n << DIV_SHIFT) / (DIV_SCALE * sum);
        if (g < GAIN_MIN) g = GAIN_MIN;
        if (g > GAIN_MAX) g = GAIN_MAX;
        return int'(g);
    endfunction

    function automatic logic [SAMPLE_W-1:0] apply_gain(input logic [SAMPLE_W-1:0] raw,
                                                       input int unsigned gain);
        longint prod;
        prod = longint'($signed(raw)) * longint'(gain);
        prod = prod >>> GAIN_FRAC;   // floor toward minus infinity
        if (prod > 32767) prod = 32767;
        if (prod < -32768) prod = -32768;
        return prod[SAMPLE_W-1:0];
    endfunction

    function automatic t_scaled_word predict_scaled_word(input logic [SAMPLE_W-1:0] raw);
        t_scaled_word    w;
        int unsigned     n;
        int unsigned     pos;
        bit              ends;
        longint unsigned mag;
        n    = eff_len(cfg_len);
        pos  = blk_count % AGN_MAX_BLOCK;
        ends = (blk_count + 1 >= n);
        if (held_ready) begin
            w.scaled = apply_gain(bank_mem[(bank_sel ^ 1) * AGN_MAX_BLOCK + pos], held_gain);
            w.valid  = 1'b1;
            w.last   = ends;
        end else begin
            w = '0;
        end
        bank_mem[bank_sel * AGN_MAX_BLOCK + pos] = raw;
        if (pos + 1 > written_top[bank_sel]) written_top[bank_sel] = pos + 1;
        mag = raw[SAMPLE_W-1] ? 65536 - longint'(raw) : longint'(raw);
        level_sum += mag;
        if (ends) begin
            held_gain  = block_gain_q412(n, level_sum);
            held_ready = 1'b1;
            bank_sel   = bank_sel ^ 1;
            blk_count  = 0;
            level_sum  = 0;
        end else begin
            blk_count++;
        end
        return w;
    endfunction

    // A new length must not read previous-bank entries that were never written.
    function automatic bit length_is_safe(input int unsigned len);
        int unsigned top;
        if (!held_ready) return 1'b1;
        top = eff_len(len) - 1;
        if (blk_count > top) top = blk_count;
        return top < written_top[bank_sel ^ 1];
    endfunction

    // ------------------------------------------------------------------------
    // monitor: check output words, then track config and input words
    // ------------------------------------------------------------------------
    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_scaled_word want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (scaled_due.size() == 0) begin
                    note_fail($sformatf("unexpected word: sample %h valid %b last %b",
                                        o_scaled_sample, o_scaled_valid, o_block_last));
                end else begin
                    want = scaled_due.pop_front();
                    if (o_scaled_sample !== want.scaled || o_scaled_valid !== want.valid
                            || o_block_last !== want.last)
                        note_fail($sformatf({"word mismatch: expected sample %h valid %b ",
                                             "last %b, got sample %h valid %b last %b"},
                                            want.scaled, want.valid, want.last,
                                            o_scaled_sample, o_scaled_valid, o_block_last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) cfg_len = i_cfg_block_length;
            if (i_valid && o_ready) scaled_due.push_back(predict_scaled_word(i_sample));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver backpressure on a pattern of its own
    t_rx_mode rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_phase = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 64);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:    i_ready <= 1'b1;
            RX_COIN:    i_ready <= 1'($urandom_range(0, 1));
            RX_CHOKE:   i_ready <= ($urandom_range(0, 7) == 0);
            default:    i_ready <= (rx_phase % 4 != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // drop valid, wait for every expected word, then let the divider finish
    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (scaled_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] len);
        settle_block();
        i_cfg_valid        <= 1'b1;
        i_cfg_block_length <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample(input t_level_style style);
        int k;
        int v;
        case (style)
            LVL_QUIET: begin
                k = $urandom_range(0, 12);
                v = $urandom_range(0, (1 << k) - 1);
                if ($urandom_range(0, 1)) v = -v;
                return SAMPLE_W'(v);
            end
            LVL_SILENT:    return '0;
            LVL_THRESHOLD: begin
                if ($urandom_range(0, 15) != 0) return '0;
                return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            end
            LVL_SPIKE:     return ($urandom_range(0, 31) == 0) ? SAMPLE_W'($urandom()) : '0;
            LVL_RAILS:     return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default:       return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // Still at the reset length: first-block words come out invalid.
    task automatic test_reset_length();
        send_word(16'h7FFF);
        send_word(16'h8000);
        send_word(16'h0000);
        send_word(16'h0001);
    endtask

    // All-ones length clamps to the full bank; run well into that first block.
    task automatic test_longest_block();
        int v;
        write_length(CFG_W'(LEN_ALL_ONES));
        repeat (60) begin
            v = $urandom_range(0, 4000);
            if ($urandom_range(0, 1)) v = -v;
            send_word(SAMPLE_W'(v));
        end
    endtask

    // Shrink below the current position: the next word closes the block.
    task automatic test_length_shrink();
        write_length(CFG_W'(5));
        repeat (3) send_word(draw_sample(LVL_FULL));
        write_length(CFG_W'(2));
        send_word(16'h1234);
    endtask

    // Zero length acts as one; each word is its own block.
    task automatic test_single_sample_blocks();
        write_length('0);
        send_word(16'h8000);
        send_word(16'h0001);
        send_word(16'h0000);
        send_word(16'h7FFF);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h0005);
    endtask

    // One LSB over 31 samples sits at the silence limit, over 30 just above it.
    task automatic test_level_threshold();
        write_length(CFG_W'(31));
        send_word(16'h0001);
        repeat (30) send_word('0);
        write_length(CFG_W'(30));
        send_word(16'h0001);
        repeat (29) send_word('0);
    endtask

    // A lone full-scale sample gets a large gain and must clip both ways.
    task automatic test_saturation();
        write_length(CFG_W'(16));
        send_word(16'h7FFF);
        repeat (15) send_word('0);
        send_word(16'h8000);
        repeat (15) send_word('0);
        repeat (16) send_word(SAMPLE_W'(-$urandom_range(1, 5000)));
        repeat (16) send_word(draw_sample(LVL_QUIET));
    endtask

    task automatic test_random_blocks();
        int unsigned  sent;
        int unsigned  len;
        int unsigned  eff;
        int unsigned  first;
        int unsigned  total;
        int unsigned  k;
        bit           long_used;
        t_level_style style;
        sent      = 0;
        long_used = 1'b0;
        style     = LVL_FULL;
        while (sent < RANDOM_WORDS) begin
            settle_block();
            k = $urandom_range(0, 99);
            if (k < 5) len = 0;
            else if (k < 10) len = 1;
            else if (k < 14 && !long_used)
                len = $urandom_range(0, 1) ? AGN_MAX_BLOCK
                                           : $urandom_range(AGN_MAX_BLOCK + 1, LEN_ALL_ONES);
            else len = $urandom_range(2, 48);
            if (!length_is_safe(len)) len = cfg_len;
            eff = eff_len(len);
            if (eff > 64) long_used = 1'b1;
            write_length(CFG_W'(len));
            first = (blk_count >= eff) ? 1 : eff - blk_count;
            total = first;
            if (eff <= 64) begin
                total += $urandom_range(0, 3) * eff;
                // leave a broken block behind now and then
                if ($urandom_range(0, 2) == 0) total += $urandom_range(0, eff - 1);
            end
            for (int unsigned i = 0; i < total; i++) begin
                if (i == 0 || (i >= first && (i - first) % eff == 0))
                    style = t_level_style'($urandom_range(0, 5));
                send_word(draw_sample(style));
            end
            sent += total;
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_sample           <= '0;
        i_cfg_valid        <= 1'b0;
        i_cfg_block_length <= '0;
        i_ready            <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_length();
        test_longest_block();
        test_length_shrink();
        test_single_sample_blocks();
        test_level_threshold();
        test_saturation();
        test_random_blocks();

        settle_block();
        if (fail_count == 0 && scaled_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
